// ===== hw/rtl/antiplane_strip_stress_kernel_core_assert.svh =====
// assertion macros used by the rtl, clocked on clk and disabled in reset
`ifndef ANTIPLANE_STRIP_STRESS_KERNEL_CORE_ASSERT_SVH
`define ANTIPLANE_STRIP_STRESS_KERNEL_CORE_ASSERT_SVH

// same-cycle implication
`define APS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// delayed implication
`define APS_ASSERT_DELAYED(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aps_pkg.sv =====
`default_nettype none

package aps_pkg;

    typedef struct packed
    {
        logic signed [31:0] receiver_horizontal;
        logic signed [31:0] receiver_depth;
        logic signed [31:0] source_horizontal;
        logic signed [31:0] source_depth;
        logic        [30:0] strip_width;
    } item_t;

    typedef struct packed
    {
        logic signed [63:0] stress;
        logic               singular;
    } result_t;

    localparam int NUM_TERMS     = 4;
    localparam int DIFF_W        = 34;
    localparam int MAG_W         = 33;
    localparam int SQ_W          = 66;
    localparam int DEN_W         = 67;
    localparam int RIG_W         = 32;
    localparam int RIG_FRAC_BITS = 16;
    localparam int K_W           = 64;
    localparam int CHUNK_W       = 32;
    localparam int PROD_SHIFT    = K_W + RIG_FRAC_BITS;

    localparam logic [RIG_W-1:0] RIGIDITY_RESET = 32'd65536;
    localparam logic [K_W-1:0]   INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

    // terms a, b, c, d: a and d enter with a negative coefficient
    localparam logic [NUM_TERMS-1:0] TERM_COEF_NEG = 4'b1001;

    localparam logic signed [63:0] STRESS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] STRESS_MIN = 64'sh8000_0000_0000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/antiplane_strip_stress_kernel_core.sv =====
`default_nettype none

// antiplane strip stress kernel, one green's function entry per word
// input: a word on item is taken at each clock edge where start is high; busy
//   is always low, so a new word may follow every cycle
// config: cfg_we writes cfg_data into the rigidity register (unsigned q16.16);
//   write only while no word is in flight
// output: done is high for exactly one cycle with the matching result word
//   (stress, singular); results leave in the order the words came in
// path: from start to done a word passes the front end (differences, magnitudes,
//   squares, denominators), the bit-per-stage dividers (one stage per quotient bit),
//   summing, sign, the rigidity and split multipliers, then the join and saturate stages
// throughput: one word per cycle, sustained
// reset: rst_n clears the pipeline valid bits and sets rigidity to 1.0;
//   words in flight are dropped
// the receiver cannot hold results off, so the pipeline never stalls
`include "antiplane_strip_stress_kernel_core_assert.svh"

module antiplane_strip_stress_kernel_core
    import aps_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire item_t            item,
    input  wire logic             cfg_we,
    input  wire logic [RIG_W-1:0] cfg_data,
    output logic                  done,
    output result_t               result
);

    localparam int SHIFT   = COORD_FRAC_BITS + RESULT_FRAC_BITS;
    localparam int QW      = SHIFT + 1;
    localparam int SUM_W   = SHIFT + 4;
    localparam int MW      = SHIFT + 3;
    localparam int P_W     = MW + RIG_W;
    localparam int PK_W    = P_W + CHUNK_W;
    localparam int FULL_W  = P_W + K_W;
    localparam int SAT_BIT = PROD_SHIFT + 63;
    localparam int EXT_W   = (FULL_W > SAT_BIT + 1) ? FULL_W : SAT_BIT + 1;
    localparam int LAT     = SHIFT + 13;

    logic [RIG_W-1:0] rigidity_reg;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rigidity_reg <= RIGIDITY_RESET;
        end
        else if (cfg_we)
        begin
            rigidity_reg <= cfg_data;
        end
    end

    // stage 1: differences
    logic signed [DIFF_W-1:0] s1_dx_next;
    logic signed [DIFF_W-1:0] s1_n_next [NUM_TERMS];
    logic signed [DIFF_W-1:0] s1_w;
    logic signed [DIFF_W-1:0] s1_dx_reg;
    logic signed [DIFF_W-1:0] s1_n_reg  [NUM_TERMS];
    logic                     s1_vld_reg;

    always_comb
    begin
        s1_w         = signed'(DIFF_W'(item.strip_width));
        s1_dx_next   = DIFF_W'(item.receiver_horizontal) - DIFF_W'(item.source_horizontal);
        s1_n_next[0] = DIFF_W'(item.receiver_depth) - DIFF_W'(item.source_depth);
        s1_n_next[1] = DIFF_W'(item.receiver_depth) + DIFF_W'(item.source_depth);
        s1_n_next[2] = DIFF_W'(item.receiver_depth) - DIFF_W'(item.source_depth) - s1_w;
        s1_n_next[3] = DIFF_W'(item.receiver_depth) + DIFF_W'(item.source_depth) + s1_w;
    end

    // stage 2: magnitudes and term signs
    logic [MAG_W-1:0]     s2_dxm_next;
    logic [MAG_W-1:0]     s2_nm_next [NUM_TERMS];
    logic [NUM_TERMS-1:0] s2_tneg_next;
    logic [MAG_W-1:0]     s2_dxm_reg;
    logic [MAG_W-1:0]     s2_nm_reg  [NUM_TERMS];
    logic [NUM_TERMS-1:0] s2_tneg_reg;
    logic                 s2_vld_reg;

    always_comb
    begin
        s2_dxm_next = s1_dx_reg[DIFF_W-1] ? MAG_W'(-s1_dx_reg) : MAG_W'(s1_dx_reg);
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            s2_nm_next[k]   = s1_n_reg[k][DIFF_W-1] ? MAG_W'(-s1_n_reg[k]) : MAG_W'(s1_n_reg[k]);
            s2_tneg_next[k] = s1_n_reg[k][DIFF_W-1] ^ TERM_COEF_NEG[k];
        end
    end

    // stage 3: squares and the zero-denominator check
    logic [SQ_W-1:0]      s3_dx2_next;
    logic [SQ_W-1:0]      s3_n2_next [NUM_TERMS];
    logic                 s3_sing_next;
    logic [SQ_W-1:0]      s3_dx2_reg;
    logic [SQ_W-1:0]      s3_n2_reg  [NUM_TERMS];
    logic [MAG_W-1:0]     s3_nm_reg  [NUM_TERMS];
    logic [NUM_TERMS-1:0] s3_tneg_reg;
    logic                 s3_sing_reg;
    logic                 s3_vld_reg;

    always_comb
    begin
        s3_dx2_next  = s2_dxm_reg * s2_dxm_reg;
        s3_sing_next = 1'b0;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            s3_n2_next[k] = s2_nm_reg[k] * s2_nm_reg[k];
            if (s2_nm_reg[k] == '0)
            begin
                s3_sing_next = 1'b1;
            end
        end
        s3_sing_next = s3_sing_next & (s2_dxm_reg == '0);
    end

    // stage 4: denominators
    logic [DEN_W-1:0]     s4_den_next [NUM_TERMS];
    logic [DEN_W-1:0]     s4_den_reg  [NUM_TERMS];
    logic [MAG_W-1:0]     s4_nm_reg   [NUM_TERMS];
    logic [NUM_TERMS-1:0] s4_tneg_reg;
    logic                 s4_sing_reg;
    logic                 s4_vld_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            s4_den_next[k] = DEN_W'(s3_dx2_reg) + DEN_W'(s3_n2_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= s1_dx_next;
        s1_n_reg    <= s1_n_next;
        s2_dxm_reg  <= s2_dxm_next;
        s2_nm_reg   <= s2_nm_next;
        s2_tneg_reg <= s2_tneg_next;
        s3_dx2_reg  <= s3_dx2_next;
        s3_n2_reg   <= s3_n2_next;
        s3_nm_reg   <= s2_nm_reg;
        s3_tneg_reg <= s2_tneg_reg;
        s3_sing_reg <= s3_sing_next;
        s4_den_reg  <= s4_den_next;
        s4_nm_reg   <= s3_nm_reg;
        s4_tneg_reg <= s3_tneg_reg;
        s4_sing_reg <= s3_sing_reg;
    end

    // four dividers in lockstep, the first one carries the word's control bits
    logic [QW-1:0]        div_quo  [NUM_TERMS];
    logic [NUM_TERMS-1:0] div_tneg;
    logic [1:0]           div0_side;
    logic                 div_vld;
    logic                 div_sing;

    assign div_tneg[0] = div0_side[0];
    assign div_sing    = div0_side[1];

    for (genvar k = 0; k < NUM_TERMS; k++)
    begin : g_div
        if (k == 0)
        begin : g_lead
            aps_div #(
                .SHIFT  (SHIFT),
                .SIDE_W (2)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (s4_vld_reg),
                .num       (s4_nm_reg[k]),
                .den       (s4_den_reg[k]),
                .side_in   ({s4_sing_reg, s4_tneg_reg[k]}),
                .out_valid (div_vld),
                .quo       (div_quo[k]),
                .side_out  (div0_side)
            );
        end
        else
        begin : g_rest
            aps_div #(
                .SHIFT  (SHIFT),
                .SIDE_W (1)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (s4_vld_reg),
                .num       (s4_nm_reg[k]),
                .den       (s4_den_reg[k]),
                .side_in   (s4_tneg_reg[k]),
                .out_valid (),
                .quo       (div_quo[k]),
                .side_out  (div_tneg[k])
            );
        end
    end

    // stage 5: signed sum of the terms
    logic signed [SUM_W-1:0] s5_sum_next;
    logic signed [SUM_W-1:0] s5_sum_reg;
    logic                    s5_sing_reg;
    logic                    s5_vld_reg;

    always_comb
    begin
        s5_sum_next = '0;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            if (div_tneg[k])
            begin
                s5_sum_next = s5_sum_next - signed'(SUM_W'(div_quo[k]));
            end
            else
            begin
                s5_sum_next = s5_sum_next + signed'(SUM_W'(div_quo[k]));
            end
        end
    end

    // stage 6: sign and magnitude
    logic [MW-1:0] s6_mag_next;
    logic [MW-1:0] s6_mag_reg;
    logic          s6_neg_reg;
    logic          s6_sing_reg;
    logic          s6_vld_reg;

    assign s6_mag_next = s5_sum_reg[SUM_W-1] ? MW'(-s5_sum_reg) : MW'(s5_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= div_vld;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_sum_reg  <= s5_sum_next;
        s5_sing_reg <= div_sing;
        s6_mag_reg  <= s6_mag_next;
        s6_neg_reg  <= s5_sum_reg[SUM_W-1];
        s6_sing_reg <= s5_sing_reg;
    end

    // scale by rigidity, then by 1/(2 pi) in two 32-bit halves
    logic [P_W-1:0]  rig_prod;
    logic [1:0]      rig_side;
    logic            rig_vld;
    logic [PK_W-1:0] pk_lo;
    logic [PK_W-1:0] pk_hi;
    logic [1:0]      pk_side;
    logic            pk_vld;

    aps_mul #(
        .A_W    (MW),
        .B_W    (RIG_W),
        .SIDE_W (2)
    ) u_mul_rig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_vld_reg),
        .a         (s6_mag_reg),
        .b         (rigidity_reg),
        .side_in   ({s6_sing_reg, s6_neg_reg}),
        .out_valid (rig_vld),
        .prod      (rig_prod),
        .side_out  (rig_side)
    );

    aps_mul #(
        .A_W    (P_W),
        .B_W    (CHUNK_W),
        .SIDE_W (2)
    ) u_mul_k_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rig_vld),
        .a         (rig_prod),
        .b         (INV_TWO_PI_Q64[CHUNK_W-1:0]),
        .side_in   (rig_side),
        .out_valid (pk_vld),
        .prod      (pk_lo),
        .side_out  (pk_side)
    );

    aps_mul #(
        .A_W    (P_W),
        .B_W    (CHUNK_W),
        .SIDE_W (1)
    ) u_mul_k_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rig_vld),
        .a         (rig_prod),
        .b         (INV_TWO_PI_Q64[K_W-1:CHUNK_W]),
        .side_in   (1'b0),
        .out_valid (),
        .prod      (pk_hi),
        .side_out  ()
    );

    // stage 7: join the halves
    logic [FULL_W-1:0] s7_full_next;
    logic [FULL_W-1:0] s7_full_reg;
    logic              s7_neg_reg;
    logic              s7_sing_reg;
    logic              s7_vld_reg;

    assign s7_full_next = (FULL_W'(pk_hi) << CHUNK_W) + FULL_W'(pk_lo);

    // stage 8: shift, saturate, sign; a singular word gives STRESS_MAX
    logic [EXT_W-1:0]     s8_ext;
    logic                 s8_sat;
    logic signed [63:0]   s8_res;
    logic signed [63:0]   s8_stress_next;
    logic signed [63:0]   out_stress_reg;
    logic                 out_sing_reg;
    logic                 out_vld_reg;

    always_comb
    begin
        s8_ext = EXT_W'(s7_full_reg);
        s8_sat = |s8_ext[EXT_W-1:SAT_BIT];
        s8_res = signed'({1'b0, s8_ext[SAT_BIT-1:PROD_SHIFT]});
        if (s7_sing_reg)
        begin
            s8_stress_next = STRESS_MAX;
        end
        else if (s8_sat)
        begin
            s8_stress_next = s7_neg_reg ? STRESS_MIN : STRESS_MAX;
        end
        else
        begin
            s8_stress_next = s7_neg_reg ? -s8_res : s8_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s7_vld_reg  <= pk_vld;
            out_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_full_reg    <= s7_full_next;
        s7_neg_reg     <= pk_side[0];
        s7_sing_reg    <= pk_side[1];
        out_stress_reg <= s8_stress_next;
        out_sing_reg   <= s7_sing_reg;
    end

    assign done            = out_vld_reg;
    assign result.stress   = out_stress_reg;
    assign result.singular = out_sing_reg;

    `APS_ASSERT_DELAYED(a_latency, start && !busy, LAT, done, "word lost in pipeline")
    `APS_ASSERT_IMPLIES(a_no_phantom, done, $past(start && !busy, LAT), "result without a word")
    `APS_ASSERT_IMPLIES(a_singular_sat, done && result.singular, result.stress == STRESS_MAX,
        "singular result not saturated")

endmodule

`default_nettype wire

// ===== hw/rtl/aps_div.sv =====
`default_nettype none

module aps_div
    import aps_pkg::*;
#(
    parameter int SHIFT  = 48,
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [MAG_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [SHIFT:0]         quo,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int QW = SHIFT + 1;

    logic              vld_reg  [QW];
    logic [QW-1:0]     quo_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];
    logic [DEN_W-1:0]  rem_reg  [QW-1];
    logic [DEN_W-1:0]  den_reg  [QW-1];

    logic              src_vld  [QW];
    logic [QW-1:0]     src_quo  [QW];
    logic [SIDE_W-1:0] src_side [QW];
    logic [DEN_W-1:0]  src_rem  [QW];
    logic [DEN_W-1:0]  src_den  [QW];

    // first step takes the whole numerator, later steps shift in zeros
    always_comb
    begin
        src_vld[0]  = in_valid;
        src_quo[0]  = '0;
        src_side[0] = side_in;
        src_rem[0]  = DEN_W'(num >> 1);
        src_den[0]  = den;
        for (int k = 1; k < QW; k++)
        begin
            src_vld[k]  = vld_reg[k-1];
            src_quo[k]  = quo_reg[k-1];
            src_side[k] = side_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_den[k]  = den_reg[k-1];
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_step
        logic [DEN_W:0]  trial;
        logic            fits;
        logic [QW-1:0]   quo_next;

        assign trial    = {src_rem[g], (g == 0) ? num[0] : 1'b0};
        assign fits     = trial >= {1'b0, src_den[g]};
        assign quo_next = {src_quo[g][QW-2:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= src_vld[g];
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[g]  <= quo_next;
            side_reg[g] <= src_side[g];
        end

        if (g < QW - 1)
        begin : g_rem
            logic [DEN_W-1:0] rem_next;

            assign rem_next = fits ? DEN_W'(trial - {1'b0, src_den[g]}) : trial[DEN_W-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= src_den[g];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/aps_mul.sv =====
`default_nettype none

module aps_mul
    import aps_pkg::*;
#(
    parameter int A_W    = 51,
    parameter int B_W    = 32,
    parameter int SIDE_W = 1
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    input  wire logic [SIDE_W-1:0]  side_in,
    output logic                    out_valid,
    output logic [A_W+B_W-1:0]      prod,
    output logic [SIDE_W-1:0]       side_out
);

    localparam int NC   = (A_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PP_W = CHUNK_W + B_W;
    localparam int P_W  = A_W + B_W;

    logic [NC*CHUNK_W-1:0] a_ext;
    logic [PP_W-1:0]       pp_next [NC];
    logic [PP_W-1:0]       pp_reg  [NC];
    logic [P_W-1:0]        prod_next;
    logic [P_W-1:0]        prod_reg;
    logic                  vld1_reg;
    logic                  vld2_reg;
    logic [SIDE_W-1:0]     side1_reg;
    logic [SIDE_W-1:0]     side2_reg;

    assign a_ext = (NC*CHUNK_W)'(a);

    // one narrow partial product per chunk of a
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            pp_next[k] = PP_W'(a_ext[k*CHUNK_W +: CHUNK_W]) * PP_W'(b);
        end
    end

    always_comb
    begin
        prod_next = '0;
        for (int k = 0; k < NC; k++)
        begin
            prod_next = prod_next + (P_W'(pp_reg[k]) << (CHUNK_W * k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg    <= pp_next;
        side1_reg <= side_in;
        prod_reg  <= prod_next;
        side2_reg <= side1_reg;
    end

    assign out_valid = vld2_reg;
    assign prod      = prod_reg;
    assign side_out  = side2_reg;

endmodule

`default_nettype wire

// ===== sim/tb_antiplane_strip_stress_kernel_core.sv =====
`default_nettype none

module tb_antiplane_strip_stress_kernel_core;
    import aps_pkg::*;

    localparam int CF_BITS     = 16;
    localparam int RF_BITS     = 32;
    localparam int LATENCY     = CF_BITS + RF_BITS + 13;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              cfg_we;
    logic [RIG_W-1:0]  cfg_data;
    logic              done;
    result_t           result;

    result_t           expected_results[$];
    logic [RIG_W-1:0]  rigidity_copy;
    int unsigned       words_sent;
    int unsigned       words_checked = 0;
    int unsigned       singular_seen = 0;
    int unsigned       saturated_seen = 0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;

    antiplane_strip_stress_kernel_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_antiplane_strip_stress_kernel_core failed");
            $finish;
        end
    end

    // one strip edge term, signed, in result units
    function automatic logic signed [127:0] edge_term(longint n, logic [127:0] dx_sq,
                                                      bit neg_coef, inout bit sing);
        logic [127:0] mag;
        logic [127:0] den;
        logic [127:0] quot;
        mag = (n < 0) ? 128'(-n) : 128'(n);
        den = dx_sq + mag * mag;
        if (den == 0)
        begin
            sing = 1'b1;
            return '0;
        end
        quot = (mag << (CF_BITS + RF_BITS)) / den;
        if ((n < 0) != neg_coef)
            quot = -quot;
        return quot;
    endfunction

    function automatic result_t kernel_stress(item_t it, logic [RIG_W-1:0] rig);
        longint xr, zr, xs, zs, w, dx, a, b;
        logic [127:0] dx_mag;
        logic [127:0] dx_sq;
        logic signed [127:0] sum;
        logic [127:0] sum_mag;
        logic [191:0] prod;
        logic [191:0] scaled;
        logic [63:0] res;
        bit sing;
        bit neg;
        result_t r;
        xr = it.receiver_horizontal;
        zr = it.receiver_depth;
        xs = it.source_horizontal;
        zs = it.source_depth;
        w = longint'({33'b0, it.strip_width});
        dx = xr - xs;
        a = zr - zs;
        b = zr + zs;
        dx_mag = (dx < 0) ? 128'(-dx) : 128'(dx);
        dx_sq = dx_mag * dx_mag;
        sing = 1'b0;
        sum = edge_term(a, dx_sq, 1'b1, sing);
        sum = sum + edge_term(b, dx_sq, 1'b0, sing);
        sum = sum + edge_term(a - w, dx_sq, 1'b0, sing);
        sum = sum + edge_term(b + w, dx_sq, 1'b1, sing);
        r.singular = sing;
        if (sing)
        begin
            r.stress = STRESS_MAX;
            return r;
        end
        neg = sum[127];
        sum_mag = neg ? -sum : sum;
        prod = {64'b0, sum_mag} * {160'b0, rig};
        prod = prod * {128'b0, INV_TWO_PI_Q64};
        scaled = prod >> PROD_SHIFT;
        if (|scaled[191:63])
        begin
            r.stress = neg ? STRESS_MIN : STRESS_MAX;
            return r;
        end
        res = scaled[63:0];
        r.stress = neg ? -res : res;
        return r;
    endfunction

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected: %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                words_checked++;
                if (want.singular)
                    singular_seen++;
                else if (want.stress == STRESS_MAX || want.stress == STRESS_MIN)
                    saturated_seen++;
                if (result.stress !== want.stress)
                begin
                    $display("%0t: stress expected %h actual %h", $time, want.stress,
                             result.stress);
                    error_count++;
                end
                if (result.singular !== want.singular)
                begin
                    $display("%0t: singular expected %b actual %b", $time, want.singular,
                             result.singular);
                    error_count++;
                end
            end
        end
    end

    // called at a rising edge, returns at the edge that accepted the word
    task automatic send_word(item_t it);
        bit was_busy;
        start <= 1'b1;
        item <= it;
        forever
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
        end
        expected_results.push_back(kernel_stress(it, rigidity_copy));
        words_sent++;
    endtask

    task automatic idle_for(int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_rigidity(logic [RIG_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        rigidity_copy = v;
    endtask

    function automatic logic [31:0] small_coord();
        return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endfunction

    function automatic item_t random_word();
        item_t it;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        it.receiver_horizontal = $urandom;
        it.receiver_depth = $urandom;
        it.source_horizontal = $urandom;
        it.source_depth = $urandom;
        it.strip_width = 31'($urandom);
        if (kind >= 3)
        begin
            it.receiver_horizontal = small_coord();
            it.receiver_depth = small_coord();
            it.source_horizontal = small_coord();
            it.source_depth = small_coord();
            it.strip_width = 31'($urandom_range(0, 32'h0020_0000));
        end
        if (kind == 8)
        begin
            // receiver on a strip edge, so the word is singular
            it.source_horizontal = it.receiver_horizontal;
            if ($urandom_range(0, 1))
                it.source_depth = it.receiver_depth;
            else
                it.source_depth = it.receiver_depth - 32'(it.strip_width);
        end
        if (kind == 9)
        begin
            it.receiver_horizontal = it.source_horizontal + 32'($urandom_range(0, 3));
            it.receiver_depth = it.source_depth + 32'($urandom_range(0, 3)) - 32'd1;
            it.strip_width = 31'($urandom_range(0, 4));
        end
        return it;
    endfunction

    function automatic item_t make_word(logic [31:0] xr, logic [31:0] zr, logic [31:0] xs,
                                        logic [31:0] zs, logic [30:0] w);
        item_t it;
        it.receiver_horizontal = xr;
        it.receiver_depth = zr;
        it.source_horizontal = xs;
        it.source_depth = zs;
        it.strip_width = w;
        return it;
    endfunction

    task automatic random_bursts(int unsigned n);
        int unsigned burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n > 0)
            begin
                send_word(random_word());
                burst--;
                n--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 7));
        end
    endtask

    task automatic test_directed;
        send_word(make_word(32'h0, 32'h0, 32'h0, 32'h0, 31'h0));
        send_word(make_word(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0001_0000, 31'h0001_0000));
        send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            31'h7FFF_FFFF));
        send_word(make_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0));
        send_word(make_word(32'h0, 32'h1, 32'h0, 32'h0, 31'h0));
        send_word(make_word(32'h1, 32'h0, 32'h0, 32'h0, 31'h1));
        send_word(make_word(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 31'h1));
        send_word(make_word(32'h0, 32'h0003_0000, 32'h0, 32'h0001_0000, 31'h0002_0000));
        send_word(make_word(32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000, 31'h0004_0000));
        send_word(make_word(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 32'h0, 31'h7FFF_FFFF));
        send_word(make_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF));
        send_word(make_word(32'h0, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF));
        send_word(make_word(32'h0, 32'h0000_0002, 32'h0, 32'h0000_0001, 31'h0000_0001));
        idle_for(1);
    endtask

    task automatic test_rigidity_extremes;
        write_rigidity(32'd1);
        test_directed();
        random_bursts(60);
        write_rigidity(32'hFFFF_FFFF);
        test_directed();
        random_bursts(60);
    endtask

    task automatic test_drain_pause;
        random_bursts(40);
        drain();
        random_bursts(40);
    endtask

    task automatic test_random_rigidity;
        repeat (6)
        begin
            write_rigidity($urandom_range(1, 32'hFFFF_FFFF));
            random_bursts(280);
        end
        write_rigidity(RIGIDITY_RESET);
        random_bursts(80);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        rigidity_copy = RIGIDITY_RESET;
        words_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_rigidity_extremes();
        test_random_rigidity();
        drain();

        $display("%0d words sent, %0d results checked over 9 rigidity settings",
                 words_sent, words_checked);
        $display("%0d singular and %0d saturated results among them",
                 singular_seen, saturated_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_antiplane_strip_stress_kernel_core passed");
        else
            $display("tb_antiplane_strip_stress_kernel_core failed");
        $finish;
    end

endmodule

`default_nettype wire
